// ===== src/dstwr_pkg.sv =====
package dstwr_pkg;

  localparam int unsigned TsW    = 32;
  localparam int unsigned NumW   = 2 * TsW;
  localparam int unsigned DvsW   = TsW + 2;
  localparam int unsigned ScaleW = 20;
  localparam int unsigned TofW   = 32;
  localparam int unsigned DistW  = 34;
  localparam int unsigned ProdW  = TofW + ScaleW;
  localparam int unsigned FracW  = 16;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(307387);

  typedef struct packed {
    logic            neg;
    logic            zero;
    logic [DvsW-1:0] dvs;
    logic [DvsW-1:0] rem;
    logic [NumW-1:0] num;
    logic [NumW-1:0] quo;
  } div_t;

endpackage

// ===== src/dstwr_if.sv =====
interface dstwr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] remote_poll_tx;
  logic [31:0] remote_resp_rx;
  logic [31:0] remote_final_tx;
  logic [31:0] local_poll_rx;
  logic [31:0] local_resp_tx;
  logic [31:0] local_final_rx;

  modport source (output valid, remote_poll_tx, remote_resp_rx, remote_final_tx,
                  local_poll_rx, local_resp_tx, local_final_rx, input ready);
  modport sink (input valid, remote_poll_tx, remote_resp_rx, remote_final_tx,
                local_poll_rx, local_resp_tx, local_final_rx, output ready);
endinterface

interface dstwr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tof_units;
  logic signed [33:0] distance_mm;
  logic               zero_divisor;
  logic               saturated;

  modport source (output valid, tof_units, distance_mm, zero_divisor, saturated,
                  input ready);
  modport sink (input valid, tof_units, distance_mm, zero_divisor, saturated,
                output ready);
endinterface

// ===== src/dstwr_front.sv =====
module dstwr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [31:0]          r_poll_tx_i,
  input  logic [31:0]          r_resp_rx_i,
  input  logic [31:0]          r_final_tx_i,
  input  logic [31:0]          l_poll_rx_i,
  input  logic [31:0]          l_resp_tx_i,
  input  logic [31:0]          l_final_rx_i,
  output logic                 vld_o,
  output dstwr_pkg::div_t      div_o
);

  localparam int unsigned TsW  = dstwr_pkg::TsW;
  localparam int unsigned NumW = dstwr_pkg::NumW;
  localparam int unsigned DvsW = dstwr_pkg::DvsW;

  logic [TsW-1:0]  rnd1_q, rnd2_q, rep1_q, rep2_q;
  logic [TsW-1:0]  rnd1_d, rnd2_d, rep1_d, rep2_d;
  logic [DvsW-1:0] dvs1_q, dvs2_q, dvs1_d;
  logic [NumW-1:0] pr_q, pp_q;
  logic [2:0]      vld_q;
  dstwr_pkg::div_t div_q, div_d;

  always_comb begin
    rnd1_d = r_resp_rx_i[TsW-1:0] - r_poll_tx_i[TsW-1:0];
    rnd2_d = l_final_rx_i[TsW-1:0] - l_resp_tx_i[TsW-1:0];
    rep1_d = l_resp_tx_i[TsW-1:0] - l_poll_rx_i[TsW-1:0];
    rep2_d = r_final_tx_i[TsW-1:0] - r_resp_rx_i[TsW-1:0];
    dvs1_d = DvsW'(rnd1_d) + DvsW'(rnd2_d) + DvsW'(rep1_d) + DvsW'(rep2_d);
  end

  always_comb begin
    div_d      = '0;
    div_d.dvs  = dvs2_q;
    div_d.zero = (dvs2_q == '0);
    div_d.neg  = (pp_q > pr_q);
    div_d.num  = div_d.neg ? (pp_q - pr_q) : (pr_q - pp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd1_q <= rnd1_d;
      rnd2_q <= rnd2_d;
      rep1_q <= rep1_d;
      rep2_q <= rep2_d;
      dvs1_q <= dvs1_d;
      pr_q   <= NumW'(rnd1_q) * NumW'(rnd2_q);
      pp_q   <= NumW'(rep1_q) * NumW'(rep2_q);
      dvs2_q <= dvs1_q;
      div_q  <= div_d;
    end
  end

  assign vld_o = vld_q[2];
  assign div_o = div_q;

endmodule

// ===== src/dstwr_div_cell.sv =====
module dstwr_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  dstwr_pkg::div_t div_i,
  output logic            vld_o,
  output dstwr_pkg::div_t div_o
);

  localparam int unsigned NumW = dstwr_pkg::NumW;
  localparam int unsigned DvsW = dstwr_pkg::DvsW;

  logic            vld_q;
  dstwr_pkg::div_t div_q, div_d;
  logic [DvsW:0]   rem_sh;
  logic            ge;

  always_comb begin
    rem_sh = {div_i.rem, div_i.num[NumW-1]};
    ge     = rem_sh >= {1'b0, div_i.dvs};
    div_d      = div_i;
    div_d.num  = {div_i.num[NumW-2:0], 1'b0};
    div_d.quo  = {div_i.quo[NumW-2:0], ge};
    div_d.rem  = ge ? DvsW'(rem_sh - {1'b0, div_i.dvs}) : rem_sh[DvsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign vld_o = vld_q;
  assign div_o = div_q;

endmodule

// ===== src/dstwr_back.sv =====
module dstwr_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  dstwr_pkg::div_t                     div_i,
  input  logic [dstwr_pkg::ScaleW-1:0]        scale_i,
  output logic                                vld_o,
  output logic signed [dstwr_pkg::TofW-1:0]   tof_o,
  output logic signed [dstwr_pkg::DistW-1:0]  dist_o,
  output logic                                zero_o,
  output logic                                sat_o
);

  localparam int unsigned NumW  = dstwr_pkg::NumW;
  localparam int unsigned TofW  = dstwr_pkg::TofW;
  localparam int unsigned DistW = dstwr_pkg::DistW;
  localparam int unsigned ProdW = dstwr_pkg::ProdW;
  localparam int unsigned FracW = dstwr_pkg::FracW;
  localparam int unsigned MagW  = ProdW - FracW + 1;

  localparam logic [TofW-1:0]  NegLim  = {1'b1, {(TofW-1){1'b0}}};
  localparam logic [TofW-1:0]  PosLim  = {1'b0, {(TofW-1){1'b1}}};
  localparam logic [MagW-1:0]  DNegMag = MagW'({1'b1, {(DistW-1){1'b0}}});
  localparam logic [MagW-1:0]  DPosMax = MagW'({1'b0, {(DistW-1){1'b1}}});

  logic [2:0]       vld_q;
  logic [TofW-1:0]  mag_d, mag_q, tof_d, tof_a_q, tof_b_q, tof_q;
  logic             neg_d, neg_a_q, neg_b_q;
  logic             sat_d, sat_a_q, sat_b_q, sat_q;
  logic             zero_a_q, zero_b_q, zero_q;
  logic [ProdW-1:0] prod_q;
  logic [MagW-1:0]  dmag;
  logic [DistW-1:0] dist_d, dist_q;
  logic             hi_nz;

  always_comb begin
    hi_nz = |div_i.quo[NumW-1:TofW];
    if (div_i.neg) begin
      sat_d = hi_nz || (div_i.quo[TofW-1] && (|div_i.quo[TofW-2:0]));
      mag_d = sat_d ? NegLim : div_i.quo[TofW-1:0];
    end else begin
      sat_d = hi_nz || div_i.quo[TofW-1];
      mag_d = sat_d ? PosLim : div_i.quo[TofW-1:0];
    end
    if (div_i.zero) begin
      sat_d = 1'b0;
      mag_d = '0;
    end
    neg_d = div_i.neg && (mag_d != '0);
    tof_d = neg_d ? (~mag_d + 1'b1) : mag_d;
  end

  always_comb begin
    if (neg_b_q) begin
      dmag = MagW'((ProdW+1)'(prod_q) + (ProdW+1)'({FracW{1'b1}}) >> FracW);
      if (dmag > DNegMag) dmag = DNegMag;
      dist_d = DistW'(~dmag + 1'b1);
    end else begin
      dmag = MagW'(prod_q >> FracW);
      if (dmag > DPosMax) dmag = DPosMax;
      dist_d = DistW'(dmag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q    <= mag_d;
      tof_a_q  <= tof_d;
      neg_a_q  <= neg_d;
      sat_a_q  <= sat_d;
      zero_a_q <= div_i.zero;
      prod_q   <= ProdW'(mag_q) * ProdW'(scale_i);
      tof_b_q  <= tof_a_q;
      neg_b_q  <= neg_a_q;
      sat_b_q  <= sat_a_q;
      zero_b_q <= zero_a_q;
      tof_q    <= tof_b_q;
      dist_q   <= dist_d;
      sat_q    <= sat_b_q;
      zero_q   <= zero_b_q;
    end
  end

  assign vld_o  = vld_q[2];
  assign tof_o  = tof_q;
  assign dist_o = dist_q;
  assign zero_o = zero_q;
  assign sat_o  = sat_q;

endmodule

// ===== src/ds_twr_time_of_flight.sv =====
// Double-sided two-way ranging: time of flight and distance.
// in_i carries the six timestamps of one exchange as one word; out_o carries
// tof_units, distance_mm, zero_divisor and saturated for that word.
// Words move on valid and ready both high at a rising edge of clk_i.
// Throughput is one word per cycle while out_o is not stalled. The front end
// registers the intervals, then the two 32x32 products, then their difference;
// a chain of 64 restoring division cells follows (one quotient bit per cell);
// the back end registers clipping, then the scale multiply, then the output.
// The whole pipeline advances together: when out_o is stalled with a word
// waiting, every stage holds and in_i.ready drops; it stays high while the
// output register is empty or being taken.
// cfg_we_i writes distance_scale (Q16 mm per unit); write only while idle.
// rst_ni clears all valid bits and sets distance_scale to 307387.
module ds_twr_time_of_flight (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,
  dstwr_in_if.sink    in_i,
  dstwr_out_if.source out_o
);

  localparam int unsigned Cells = dstwr_pkg::NumW;

  logic [dstwr_pkg::ScaleW-1:0] scale_q;
  logic                         en;
  logic [Cells:0]               vld;
  dstwr_pkg::div_t              div [Cells+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= dstwr_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  dstwr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vld_i        (in_i.valid),
    .r_poll_tx_i  (in_i.remote_poll_tx),
    .r_resp_rx_i  (in_i.remote_resp_rx),
    .r_final_tx_i (in_i.remote_final_tx),
    .l_poll_rx_i  (in_i.local_poll_rx),
    .l_resp_tx_i  (in_i.local_resp_tx),
    .l_final_rx_i (in_i.local_final_rx),
    .vld_o        (vld[0]),
    .div_o        (div[0])
  );

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    dstwr_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[g]),
      .div_i  (div[g]),
      .vld_o  (vld[g+1]),
      .div_o  (div[g+1])
    );
  end

  dstwr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vld[Cells]),
    .div_i   (div[Cells]),
    .scale_i (scale_q),
    .vld_o   (out_o.valid),
    .tof_o   (out_o.tof_units),
    .dist_o  (out_o.distance_mm),
    .zero_o  (out_o.zero_divisor),
    .sat_o   (out_o.saturated)
  );

  a_zero_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_divisor |-> out_o.tof_units == 0 && !out_o.saturated)
    else $error("zero divisor word carries nonzero result");

  a_tof0_dist0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.tof_units == 0 |-> out_o.distance_mm == 0)
    else $error("zero tof with nonzero distance");

  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.tof_units[31] |-> !out_o.distance_mm[33])
    else $error("distance sign disagrees with tof");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] tof;
    logic signed [33:0] dmm;
    logic               zdiv;
    logic               sat;
  } ranging_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [19:0] cfg_wdata_i = '0;

  dstwr_in_if  in_if ();
  dstwr_out_if out_if ();

  ds_twr_time_of_flight uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ranging_t    expected_q[$];
  logic [19:0] scale = dstwr_pkg::ScaleReset;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          long_hold = 1'b0;
  bit          rx_stall_on = 1'b1;

  initial begin
    in_if.valid = 1'b0;
    in_if.remote_poll_tx = '0;
    in_if.remote_resp_rx = '0;
    in_if.remote_final_tx = '0;
    in_if.local_poll_rx = '0;
    in_if.local_resp_tx = '0;
    in_if.local_final_rx = '0;
    out_if.ready = 1'b0;
  end

  function automatic ranging_t predict_range(logic [31:0] rpt, logic [31:0] rrr,
                                             logic [31:0] rft, logic [31:0] lpr,
                                             logic [31:0] lrt, logic [31:0] lfr);
    logic [31:0]  round1, round2, reply1, reply2;
    logic [33:0]  dvs;
    logic [63:0]  pr, pp, mag, quo;
    logic [31:0]  tmag;
    logic [51:0]  prod;
    logic [52:0]  dmag;
    logic         neg;
    ranging_t     r;
    round1 = rrr - rpt;
    round2 = lfr - lrt;
    reply1 = lrt - lpr;
    reply2 = rft - rrr;
    dvs = 34'(round1) + 34'(round2) + 34'(reply1) + 34'(reply2);
    r.zdiv = 1'b0;
    r.sat = 1'b0;
    if (dvs == 0) begin
      r.tof = '0;
      r.dmm = '0;
      r.zdiv = 1'b1;
      return r;
    end
    pr = 64'(round1) * 64'(round2);
    pp = 64'(reply1) * 64'(reply2);
    neg = pr < pp;
    mag = neg ? pp - pr : pr - pp;
    quo = mag / 64'(dvs);
    if (neg) begin
      if (quo > 64'h8000_0000) begin
        tmag = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        tmag = quo[31:0];
      end
      if (tmag == 0) neg = 1'b0;
      r.tof = -tmag;
    end else begin
      if (quo > 64'h7FFF_FFFF) begin
        tmag = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else begin
        tmag = quo[31:0];
      end
      r.tof = tmag;
    end
    prod = 52'(tmag) * 52'(scale);
    if (neg) begin
      dmag = (53'(prod) + 53'hFFFF) >> 16;
      if (dmag > 53'h2_0000_0000) dmag = 53'h2_0000_0000;
      r.dmm = -dmag[33:0];
    end else begin
      dmag = 53'(prod) >> 16;
      if (dmag > 53'h1_FFFF_FFFF) dmag = 53'h1_FFFF_FFFF;
      r.dmm = dmag[33:0];
    end
    return r;
  endfunction

  task automatic send_exchange(logic [31:0] rpt, logic [31:0] rrr, logic [31:0] rft,
                               logic [31:0] lpr, logic [31:0] lrt, logic [31:0] lfr);
    in_if.valid <= 1'b1;
    in_if.remote_poll_tx <= rpt;
    in_if.remote_resp_rx <= rrr;
    in_if.remote_final_tx <= rft;
    in_if.local_poll_rx <= lpr;
    in_if.local_resp_tx <= lrt;
    in_if.local_final_rx <= lfr;
    do @(posedge clk_i); while (!in_if.ready);
    expected_q.push_back(predict_range(rpt, rrr, rft, lpr, lrt, lfr));
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [19:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scale = v;
  endtask

  // realistic exchange: start point random, intervals random up to mask
  task automatic send_random_exchange(int unsigned mask);
    logic [31:0] t0, t3, r1, p1, p2, tof;
    t0 = $urandom();
    t3 = $urandom();
    tof = $urandom() & (mask >> 8);
    p1 = $urandom() & mask;
    p2 = $urandom() & mask;
    r1 = 2 * tof + p1;
    send_exchange(t0, t0 + r1, t0 + r1 + p2, t3, t3 + p1, t3 + p1 + 2 * tof + p2);
  endtask

  task automatic send_noise();
    send_exchange($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic test_directed();
    send_exchange(0, 0, 0, 0, 0, 0);
    send_exchange(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_exchange(100, 1100, 1600, 5000, 5500, 6500);
    send_exchange(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
    send_exchange(0, 1, 1, 0, 0, 1);
    send_exchange(0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_exchange(0, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_exchange(32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFF0, 0, 5);
    send_exchange(0, 32'h8000_0000, 32'h8000_0001, 0, 1, 32'h8000_0001);
    send_exchange(0, 1, 32'h4000_0001, 0, 32'h4000_0000, 32'h4000_0001);
    send_exchange(0, 2, 32'h1000_0002, 0, 32'h1000_0000, 32'h1000_0002);
    send_exchange(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_exchange(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_exchange(0, 32'hFFFF_0000, 32'hFFFF_0001, 0, 1, 32'hFFFF_0001);
    drain();
  endtask

  task automatic test_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && sent < count) begin
        case ($urandom_range(0, 9))
          0, 1: send_noise();
          2: send_random_exchange(32'hFFFF_FFFF);
          3: send_exchange(32'(sent), 32'(sent), 32'(sent), 7, 7, 7);
          default: send_random_exchange($urandom_range(0, 1) ? 32'hFFFF : 32'hFFF_FFFF);
        endcase
        burst--;
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    repeat (200) send_noise();
    drain();
  endtask

  always @(posedge clk_i) begin
    if (long_hold) begin
      out_if.ready <= 1'b0;
      repeat (400) @(posedge clk_i);
      long_hold <= 1'b0;
    end else if (!rx_stall_on) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 499) == 0) rx_stall_on <= !rx_stall_on;
  end

  always @(posedge clk_i) begin
    ranging_t e;
    if (out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word tof=%0d", out_if.tof_units);
      end else begin
        e = expected_q.pop_front();
        if (out_if.tof_units !== e.tof || out_if.distance_mm !== e.dmm ||
            out_if.zero_divisor !== e.zdiv || out_if.saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp tof=%0d dist=%0d z=%b s=%b got tof=%0d dist=%0d z=%b s=%b",
                     e.tof, e.dmm, e.zdiv, e.sat, out_if.tof_units,
                     out_if.distance_mm, out_if.zero_divisor, out_if.saturated);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_scale(20'h0_0000);
    test_random(300);
    drain();
    write_scale(20'hF_FFFF);
    test_directed();
    test_random(400);
    drain();
    write_scale(20'h0_0001);
    test_backpressure();
    write_scale(20'($urandom()));
    test_random(500);
    drain();
    write_scale(dstwr_pkg::ScaleReset);
    test_random(470);
    drain();
    if (mismatches == 0 && expected_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

// ===== sim.f =====
src/dstwr_pkg.sv
src/dstwr_if.sv
src/dstwr_front.sv
src/dstwr_div_cell.sv
src/dstwr_back.sv
src/ds_twr_time_of_flight.sv
verif/testbench.sv
